// ===== design/ssi_pkg.sv =====
// ----------------------------------------------------------------------------
// ssi_pkg: sorted set intersection shared types
// Constants, opcodes, request/result structs and controller states.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int SET_DEPTH = 64;
  localparam int ADDR_W    = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int VAL_W     = 31;

  localparam logic [CNT_W-1:0] SET_FULL = CNT_W'(SET_DEPTH);

  typedef enum logic [1:0] {
    OP_APPEND_A  = 2'd0,
    OP_APPEND_B  = 2'd1,
    OP_INTERSECT = 2'd2,
    OP_CLEAR     = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]   element;
    logic               last;
    logic               empty_res;
    logic               overflowed;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_FIN  = 2'd2
  } state_t;

endpackage

// ===== design/ssi_ram.sv =====
// ----------------------------------------------------------------------------
// ssi_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ssi_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ssi_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssi_ctrl: set loader and merge-walk controller
// Handles appends and clear; walks both stores one compare per cycle unless
// stalled, holding the latest match back so the final one is marked last.
// ----------------------------------------------------------------------------
module ssi_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  ssi_pkg::cmd_t               cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output ssi_pkg::rsp_t               rsp,
  output logic                        wr_a_en,
  output logic                        wr_b_en,
  output logic [ssi_pkg::ADDR_W-1:0]  wr_a_addr,
  output logic [ssi_pkg::ADDR_W-1:0]  wr_b_addr,
  output logic [ssi_pkg::VAL_W-1:0]   wr_data,
  output logic [ssi_pkg::ADDR_W-1:0]  rd_a_addr,
  output logic [ssi_pkg::ADDR_W-1:0]  rd_b_addr,
  input  logic [ssi_pkg::VAL_W-1:0]   rd_a_data,
  input  logic [ssi_pkg::VAL_W-1:0]   rd_b_data
);

  ssi_pkg::state_t              state, state_next;
  logic [ssi_pkg::CNT_W-1:0]    count_a, count_b;
  logic                         overflow_flag;
  logic [ssi_pkg::CNT_W-1:0]    ia, ia_next, ib, ib_next;
  logic [ssi_pkg::VAL_W-1:0]    pend, pend_next;
  logic                         have, have_next;
  logic                         push;
  ssi_pkg::rsp_t                push_data;

  logic accept, slot_free, walk_done, match;

  assign cmd_stall = (state != ssi_pkg::ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign walk_done = (ia >= count_a) || (ib >= count_b);
  assign match     = (rd_a_data == rd_b_data);

  assign wr_data   = cmd.value;
  assign wr_a_addr = count_a[ssi_pkg::ADDR_W-1:0];
  assign wr_b_addr = count_b[ssi_pkg::ADDR_W-1:0];
  assign wr_a_en   = accept && (cmd.opcode == ssi_pkg::OP_APPEND_A)
                     && (count_a != ssi_pkg::SET_FULL);
  assign wr_b_en   = accept && (cmd.opcode == ssi_pkg::OP_APPEND_B)
                     && (count_b != ssi_pkg::SET_FULL);

  // read address follows the next index so the data lines up with ia/ib
  assign rd_a_addr = ia_next[ssi_pkg::ADDR_W-1:0];
  assign rd_b_addr = ib_next[ssi_pkg::ADDR_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ssi_pkg::ST_IDLE: begin
        if (accept && (cmd.opcode == ssi_pkg::OP_INTERSECT)) begin
          state_next = ssi_pkg::ST_WALK;
        end
      end
      ssi_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = ssi_pkg::ST_FIN;
        end
      end
      ssi_pkg::ST_FIN: begin
        if (slot_free) begin
          state_next = ssi_pkg::ST_IDLE;
        end
      end
      default: state_next = ssi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ia_next   = ia;
    ib_next   = ib;
    pend_next = pend;
    have_next = have;
    push      = 1'b0;
    push_data = '0;
    case (state)
      ssi_pkg::ST_IDLE: begin
        if (accept && (cmd.opcode == ssi_pkg::OP_INTERSECT)) begin
          ia_next   = '0;
          ib_next   = '0;
          have_next = 1'b0;
        end
      end
      ssi_pkg::ST_WALK: begin
        if (!walk_done) begin
          if (match) begin
            // a held match can only be released once the output slot opens
            if (!have || slot_free) begin
              push                 = have;
              push_data.element    = pend;
              push_data.overflowed = overflow_flag;
              pend_next            = rd_a_data;
              have_next            = 1'b1;
              ia_next              = ia + ssi_pkg::CNT_W'(1);
              ib_next              = ib + ssi_pkg::CNT_W'(1);
            end
          end else if (rd_a_data < rd_b_data) begin
            ia_next = ia + ssi_pkg::CNT_W'(1);
          end else begin
            ib_next = ib + ssi_pkg::CNT_W'(1);
          end
        end
      end
      ssi_pkg::ST_FIN: begin
        if (slot_free) begin
          push                 = 1'b1;
          push_data.element    = have ? pend : '0;
          push_data.last       = 1'b1;
          push_data.empty_res  = !have;
          push_data.overflowed = overflow_flag;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ssi_pkg::ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
      have          <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      have  <= have_next;
      if (accept) begin
        case (cmd.opcode)
          ssi_pkg::OP_APPEND_A: begin
            if (wr_a_en) begin
              count_a <= count_a + ssi_pkg::CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          ssi_pkg::OP_APPEND_B: begin
            if (wr_b_en) begin
              count_b <= count_b + ssi_pkg::CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          ssi_pkg::OP_CLEAR: begin
            count_a       <= '0;
            count_b       <= '0;
            overflow_flag <= 1'b0;
          end
          default: ;
        endcase
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ia   <= ia_next;
    ib   <= ib_next;
    pend <= pend_next;
    if (push) begin
      rsp <= push_data;
    end
  end

endmodule

// ===== design/sorted_set_intersection.sv =====
// ----------------------------------------------------------------------------
// sorted_set_intersection: merge-walk intersection of two stored sets
// Two 64-entry stores loaded by append requests; an intersect request
// streams the common values in ascending order, the final one marked last.
// ----------------------------------------------------------------------------
//
//  channel  | valid     | stall     | payload          | carries
//  ---------+-----------+-----------+------------------+------------------------
//  request  | cmd_valid | cmd_stall | cmd (cmd_t)      | opcode, value
//  result   | rsp_valid | rsp_stall | rsp (rsp_t)      | element, last,
//           |           |           |                  | empty_res, overflowed
//
//  Append and clear requests complete on acceptance and give no result.
//  During an intersect the walk does one compare per cycle on the registered
//  read ports of the two set RAMs.
//  cmd_stall is high for the whole walk; rsp_stall holds the walk only when
//  a new match finds the output register still occupied.
//  Synchronous reset clears counts, overflow flag and control; RAM
//  contents are left as they are.
//
module sorted_set_intersection (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ssi_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ssi_pkg::rsp_t rsp
);

  logic                        wr_a_en, wr_b_en;
  logic [ssi_pkg::ADDR_W-1:0]  wr_a_addr, wr_b_addr, rd_a_addr, rd_b_addr;
  logic [ssi_pkg::VAL_W-1:0]   wr_data, rd_a_data, rd_b_data;

  ssi_ram #(
    .DEPTH (ssi_pkg::SET_DEPTH),
    .WIDTH (ssi_pkg::VAL_W)
  ) u_set_a (
    .clk   (clk),
    .we    (wr_a_en),
    .waddr (wr_a_addr),
    .wdata (wr_data),
    .raddr (rd_a_addr),
    .rdata (rd_a_data)
  );

  ssi_ram #(
    .DEPTH (ssi_pkg::SET_DEPTH),
    .WIDTH (ssi_pkg::VAL_W)
  ) u_set_b (
    .clk   (clk),
    .we    (wr_b_en),
    .waddr (wr_b_addr),
    .wdata (wr_data),
    .raddr (rd_b_addr),
    .rdata (rd_b_data)
  );

  ssi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_a_en   (wr_a_en),
    .wr_b_en   (wr_b_en),
    .wr_a_addr (wr_a_addr),
    .wr_b_addr (wr_b_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

endmodule

// ===== sim/ssi_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_result_checker: result prediction and comparison
// Watches both channels. Keeps its own copy of the two sets, the counts and
// the sticky overflow flag. Expands each intersect request into the expected
// results, then compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module ssi_result_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  ssi_pkg::cmd_t cmd,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  ssi_pkg::rsp_t rsp,
  output int            failures,
  output int            pending
);
  import ssi_pkg::*;

  logic [VAL_W-1:0] members_a [SET_DEPTH];
  logic [VAL_W-1:0] members_b [SET_DEPTH];
  int               size_a;
  int               size_b;
  logic             dropped;
  rsp_t             expected_matches [$];

  task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected element=%0d last=%b empty_res=%b overflowed=%b,",
               $time, what, want.element, want.last, want.empty_res, want.overflowed,
               " got element=%0d last=%b empty_res=%b overflowed=%b",
               got.element, got.last, got.empty_res, got.overflowed);
  endtask

  // Merge walk over both sets; equal heads emit and advance both sides.
  task automatic queue_intersection();
    int   ia;
    int   ib;
    int   hits;
    rsp_t r;
    ia   = 0;
    ib   = 0;
    hits = 0;
    while (ia < size_a && ib < size_b) begin
      if (members_a[ia] == members_b[ib]) begin
        r.element    = members_a[ia];
        r.last       = 1'b0;
        r.empty_res  = 1'b0;
        r.overflowed = dropped;
        expected_matches.push_back(r);
        hits++;
        ia++;
        ib++;
      end else if (members_a[ia] < members_b[ib]) begin
        ia++;
      end else begin
        ib++;
      end
    end
    if (hits == 0) begin
      r.element    = '0;
      r.last       = 1'b1;
      r.empty_res  = 1'b1;
      r.overflowed = dropped;
      expected_matches.push_back(r);
    end else begin
      r      = expected_matches.pop_back();
      r.last = 1'b1;
      expected_matches.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      size_a   = 0;
      size_b   = 0;
      dropped  = 1'b0;
      failures = 0;
      expected_matches.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_matches.size() == 0) begin
          want = '0;
          report_mismatch("result with nothing outstanding", want, rsp);
        end else begin
          want = expected_matches.pop_front();
          if (rsp !== want)
            report_mismatch("result mismatch", want, rsp);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        case (cmd.opcode)
          OP_APPEND_A: begin
            if (size_a < SET_DEPTH) begin
              members_a[size_a] = cmd.value;
              size_a++;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_APPEND_B: begin
            if (size_b < SET_DEPTH) begin
              members_b[size_b] = cmd.value;
              size_b++;
            end else begin
              dropped = 1'b1;
            end
          end
          OP_INTERSECT: queue_intersection();
          OP_CLEAR: begin
            size_a  = 0;
            size_b  = 0;
            dropped = 1'b0;
          end
        endcase
      end
    end
    pending = expected_matches.size();
  end

endmodule

// ===== sim/sorted_set_intersection_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_intersection_test: top of the intersection testbench
// Resets the block, sends a directed list of requests and then random
// sorted set pairs with noise, one full-capacity pair with overflow, and
// random idling on both channels. The checker does all comparison.
// ----------------------------------------------------------------------------
module sorted_set_intersection_test;
  import ssi_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 5;
  localparam int TARGET_REQUESTS = 270;
  localparam int RESULT_HOLD     = 300;
  localparam int DRAIN_CYCLES    = 2 * SET_DEPTH + 16;
  localparam int QUIET_LIMIT     = 2000;
  localparam logic [VAL_W-1:0] VALUE_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   failures;
  int   pending;
  int   requests_sent = 0;
  int   quiet_cycles  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  sorted_set_intersection DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ssi_result_checker check_results (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  function automatic logic [VAL_W-1:0] any_value();
    return VAL_W'($urandom());
  endfunction

  task automatic send_request(input opcode_t op, input logic [VAL_W-1:0] v);
    cmd_t req;
    req.opcode = op;
    req.value  = v;
    // no idling while requests 120..169 go out
    while (!(requests_sent >= 120 && requests_sent < 170) && $urandom_range(99) < 9) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= req;
    do @(posedge clk); while (cmd_stall);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ascending stream spread over the value range; each element goes to A, B
  // or both. A zero step now and then gives duplicates.
  task automatic load_set_pair(input int n, input int common_pct);
    logic [VAL_W-1:0] side_a [$];
    logic [VAL_W-1:0] side_b [$];
    int unsigned      span;
    int unsigned      cur;
    int               pick;
    span = 32'h7FFF_FFFF / (n + 1);
    cur  = $urandom_range(span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < common_pct) pick = 2;
      else pick = $urandom_range(1);
      if (pick != 1) side_a.push_back(cur[VAL_W-1:0]);
      if (pick != 0) side_b.push_back(cur[VAL_W-1:0]);
      if ($urandom_range(9) != 0) cur += 1 + $urandom_range(span - 1);
    end
    while (side_a.size() != 0 || side_b.size() != 0) begin
      if (side_b.size() == 0 || (side_a.size() != 0 && $urandom_range(1) == 0))
        send_request(OP_APPEND_A, side_a.pop_front());
      else
        send_request(OP_APPEND_B, side_b.pop_front());
    end
  endtask

  initial begin : request_side
    int roll;
    bit filled;
    filled    = 1'b0;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // both sets empty, then one side empty
    send_request(OP_INTERSECT, VALUE_MAX);
    send_request(OP_APPEND_A, '0);
    send_request(OP_APPEND_A, VALUE_MAX);
    send_request(OP_INTERSECT, '0);
    // value extremes match; the receiver's long hold lands on this run
    send_request(OP_APPEND_B, '0);
    send_request(OP_APPEND_B, VALUE_MAX);
    send_request(OP_INTERSECT, '0);
    send_request(OP_CLEAR, VALUE_MAX);
    // disjoint sets
    send_request(OP_APPEND_A, 31'h2AAA_AAAA);
    send_request(OP_APPEND_B, 31'h5555_5555);
    send_request(OP_INTERSECT, VALUE_MAX);
    wait_for_results();
    send_request(OP_CLEAR, '0);
    // duplicates pair off, then unsorted tails
    send_request(OP_APPEND_A, 31'd3);
    send_request(OP_APPEND_A, 31'd3);
    send_request(OP_APPEND_B, 31'd3);
    send_request(OP_APPEND_B, 31'd3);
    send_request(OP_APPEND_B, 31'd3);
    send_request(OP_INTERSECT, '0);
    send_request(OP_APPEND_A, 31'd9);
    send_request(OP_APPEND_A, 31'd2);
    send_request(OP_APPEND_B, 31'd2);
    send_request(OP_APPEND_B, 31'd9);
    send_request(OP_INTERSECT, '0);
    send_request(OP_CLEAR, '0);

    while (requests_sent < TARGET_REQUESTS) begin
      roll = $urandom_range(99);
      if (!filled && requests_sent > 60) begin
        // both sets full of equal values, one extra append each overflows
        filled = 1'b1;
        send_request(OP_CLEAR, any_value());
        load_set_pair(SET_DEPTH, 100);
        send_request(OP_APPEND_A, any_value());
        send_request(OP_APPEND_B, any_value());
        send_request(OP_INTERSECT, any_value());
        wait_for_results();
        send_request(OP_CLEAR, any_value());
        send_request(OP_INTERSECT, any_value());
      end else if (roll < 10) begin
        send_request(opcode_t'($urandom_range(3)), any_value());
      end else begin
        // skipping the clear lets sets pile up, unsorted and possibly full
        if (roll >= 25) send_request(OP_CLEAR, any_value());
        load_set_pair(($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(8),
                      60);
        send_request(OP_INTERSECT, any_value());
        if ($urandom_range(9) == 0) send_request(OP_INTERSECT, any_value());
        if ($urandom_range(4) == 0) wait_for_results();
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0)
      $display("** sorted_set_intersection: PASSED **");
    else
      $display("** sorted_set_intersection: FAILED **");
    $finish;
  end

  initial begin : result_side
    int taken;
    int hold;
    bit held;
    taken     = 0;
    hold      = 0;
    held      = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        taken++;
        // first run with more to come: block the output for a long stretch
        if (!held && !rsp.last) begin
          held = 1'b1;
          hold = RESULT_HOLD;
        end
      end
      if (hold > 0) begin
        hold--;
        rsp_stall <= 1'b1;
      end else if (taken >= 40 && taken < 110) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** sorted_set_intersection: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sorted_set_intersection.f =====
design/ssi_pkg.sv
design/ssi_ram.sv
design/ssi_ctrl.sv
design/sorted_set_intersection.sv
sim/ssi_result_checker.sv
sim/sorted_set_intersection_test.sv
